// ----- rtl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared constants, types and helpers of the binary min-heap queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ADDR_W-1:0]        t_addr;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

    // heap position (1-based) to store address
    function automatic t_addr pos2addr(input t_cnt pos);
        t_cnt tmp;
        tmp = pos - t_cnt'(1);
        return tmp[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/bmhq_req_if.sv -----
// ----------------------------------------------------------------------------
// bmhq_req_if
// request channel: push or pop item with valid/ready handshake
// ----------------------------------------------------------------------------
interface bmhq_req_if;
    logic            valid;
    logic            ready;
    logic            func;
    bmhq_pkg::t_data value;

    modport source(output valid, output func, output value, input ready);
    modport sink(input valid, input func, input value, output ready);
endinterface

// ----- rtl/bmhq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bmhq_rsp_if
// response channel: top value, count and status with valid/ready handshake
// ----------------------------------------------------------------------------
interface bmhq_rsp_if;
    logic            valid;
    logic            ready;
    bmhq_pkg::t_data top_value;
    bmhq_pkg::t_cnt  count;
    logic [1:0]      status;

    modport source(output valid, output top_value, output count, output status,
                   input ready);
    modport sink(input valid, input top_value, input count, input status,
                 output ready);
endinterface

// ----- rtl/bmhq_ram.sv -----
// ----------------------------------------------------------------------------
// bmhq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bmhq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmhq_ctrl
// heap sequencer: sift-up and sift-down over the store, hole method
// ----------------------------------------------------------------------------
module bmhq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bmhq_req_if.sink            i_req,
    bmhq_rsp_if.source          o_rsp,
    output bmhq_pkg::t_mem_req  o_mem,
    input  bmhq_pkg::t_data     i_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_FIN,
        S_DN_LAST,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_DONE
    } t_state;

    t_state            r_state,  n_state;
    bmhq_pkg::t_cnt    r_count,  n_count;
    bmhq_pkg::t_cnt    r_pos,    n_pos;
    bmhq_pkg::t_data   r_v,      n_v;
    bmhq_pkg::t_data   r_left,   n_left;
    bmhq_pkg::t_data   r_root,   n_root;
    bmhq_pkg::t_status r_status, n_status;
    logic              r_out_valid, n_out_valid;
    bmhq_pkg::t_data   r_out_top,   n_out_top;
    bmhq_pkg::t_cnt    r_out_count, n_out_count;
    bmhq_pkg::t_status r_out_status, n_out_status;

    bmhq_pkg::t_mem_req mem;
    logic [bmhq_pkg::CNT_W:0] left_wide;
    bmhq_pkg::t_cnt    left_pos;
    bmhq_pkg::t_cnt    parent;
    bmhq_pkg::t_cnt    new_cnt;
    logic              pick_right;
    bmhq_pkg::t_data   kid_val;
    bmhq_pkg::t_cnt    kid_pos;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_v          = r_v;
        n_left       = r_left;
        n_root       = r_root;
        n_status     = r_status;
        n_out_valid  = r_out_valid & ~o_rsp.ready;
        n_out_top    = r_out_top;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        mem          = '0;

        left_wide  = {r_pos, 1'b0};
        left_pos   = left_wide[bmhq_pkg::CNT_W-1:0];
        parent     = r_pos >> 1;
        new_cnt    = r_count + bmhq_pkg::t_cnt'(1);
        pick_right = (i_rdata < r_left);
        kid_val    = pick_right ? i_rdata : r_left;
        kid_pos    = pick_right ? (left_pos + bmhq_pkg::t_cnt'(1)) : left_pos;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_status = bmhq_pkg::ST_OK;
                    n_state  = S_DONE;
                    if (i_req.func == bmhq_pkg::FUNC_PUSH) begin
                        if (r_count == bmhq_pkg::t_cnt'(bmhq_pkg::CAPACITY)) begin
                            n_status = bmhq_pkg::ST_FULL;
                        end else begin
                            n_count = new_cnt;
                            n_pos   = new_cnt;
                            n_v     = i_req.value;
                            if (r_count == '0) begin
                                mem.we    = 1'b1;
                                mem.waddr = '0;
                                mem.wdata = i_req.value;
                            end else begin
                                mem.re    = 1'b1;
                                mem.raddr = bmhq_pkg::pos2addr(new_cnt >> 1);
                                n_state   = S_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = bmhq_pkg::ST_EMPTY;
                        end else if (r_count == bmhq_pkg::t_cnt'(1)) begin
                            n_count = '0;
                        end else begin
                            mem.re    = 1'b1;
                            mem.raddr = bmhq_pkg::pos2addr(r_count);
                            n_count   = r_count - bmhq_pkg::t_cnt'(1);
                            n_state   = S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_CMP: begin
                mem.we    = 1'b1;
                mem.waddr = bmhq_pkg::pos2addr(r_pos);
                if (r_v < i_rdata) begin
                    mem.wdata = i_rdata;
                    n_pos     = parent;
                    if (parent == bmhq_pkg::t_cnt'(1)) begin
                        n_state = S_UP_FIN;
                    end else begin
                        mem.re    = 1'b1;
                        mem.raddr = bmhq_pkg::pos2addr(parent >> 1);
                    end
                end else begin
                    mem.wdata = r_v;
                    n_state   = S_DONE;
                end
            end
            S_UP_FIN: begin
                mem.we    = 1'b1;
                mem.waddr = '0;
                mem.wdata = r_v;
                n_state   = S_DONE;
            end
            S_DN_LAST: begin
                n_v     = i_rdata;
                n_pos   = bmhq_pkg::t_cnt'(1);
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (left_wide > {1'b0, r_count}) begin
                    mem.we    = 1'b1;
                    mem.waddr = bmhq_pkg::pos2addr(r_pos);
                    mem.wdata = r_v;
                    n_state   = S_DONE;
                end else begin
                    mem.re    = 1'b1;
                    mem.raddr = bmhq_pkg::pos2addr(left_pos);
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                n_left = i_rdata;
                if (left_pos < r_count) begin
                    mem.re    = 1'b1;
                    mem.raddr = bmhq_pkg::pos2addr(left_pos + bmhq_pkg::t_cnt'(1));
                    n_state   = S_DN_R;
                end else begin
                    mem.we    = 1'b1;
                    mem.waddr = bmhq_pkg::pos2addr(r_pos);
                    if (i_rdata < r_v) begin
                        mem.wdata = i_rdata;
                        n_pos     = left_pos;
                        n_state   = S_DN_RD;
                    end else begin
                        mem.wdata = r_v;
                        n_state   = S_DONE;
                    end
                end
            end
            S_DN_R: begin
                mem.we    = 1'b1;
                mem.waddr = bmhq_pkg::pos2addr(r_pos);
                if (kid_val < r_v) begin
                    mem.wdata = kid_val;
                    n_pos     = kid_pos;
                    n_state   = S_DN_RD;
                end else begin
                    mem.wdata = r_v;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_top    = (r_count != '0) ? r_root : '0;
                    n_out_count  = r_count;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // root shadow, kept in step with every write to the first entry
        if (mem.we && (mem.waddr == '0)) begin
            n_root = mem.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_v          <= n_v;
        r_left       <= n_left;
        r_root       <= n_root;
        r_status     <= n_status;
        r_out_top    <= n_out_top;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.top_value = r_out_top;
    assign o_rsp.count     = r_out_count;
    assign o_rsp.status    = r_out_status;
    assign o_mem           = mem;

endmodule

// ----- rtl/binary_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// priority queue of signed 32-bit values held as a binary min-heap in a ram
// ----------------------------------------------------------------------------
// push: sift-up via S_UP_CMP and S_UP_FIN; no sift on an empty or full heap
// pop: the last entry sifts down from the root via S_DN_LAST, S_DN_RD, S_DN_L, S_DN_R
// throughput: one item at a time, set by the single read port of the heap ram
// next item is taken once the result sits in the output register
// reset clears the count and handshake state, the ram is not cleared
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmhq_req_if.sink   i_req,
    bmhq_rsp_if.source o_rsp
);

    bmhq_pkg::t_mem_req mem;
    bmhq_pkg::t_data    rdata;

    bmhq_ram #(
        .WIDTH(bmhq_pkg::DATA_W),
        .DEPTH(bmhq_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    bmhq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (mem),
        .i_rdata (rdata)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("item accepted while another is in work");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == bmhq_pkg::ST_EMPTY)
            |-> (o_rsp.count == '0) && (o_rsp.top_value == '0))
        else $error("pop on empty with nonzero result");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == bmhq_pkg::ST_FULL)
            |-> (o_rsp.count == bmhq_pkg::t_cnt'(bmhq_pkg::CAPACITY)))
        else $error("push dropped while not full");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.count == '0) |-> (o_rsp.top_value == '0))
        else $error("empty heap with nonzero top");

endmodule
